### hw/rtl/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg: shared types and codes of the indexed list
// Operation, position mode and status codes, field widths, sequencer states.
// ----------------------------------------------------------------------------
package ilir_pkg;

	localparam int DEF_LIST_CAPACITY = 64;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int LEN_W   = 7;
	localparam int OP_W    = 2;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [MODE_W-1:0] MODE_INDEX = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LAST  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_FETCH,
		S_MOVE,
		S_RESP
	} state_t;

endpackage

### hw/rtl/indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove: ordered list of signed words with indexed access
// Inserts, removes or reads one element per item; shifts the store in place.
// ----------------------------------------------------------------------------
// Usage
//   Input: drive operation, position_mode, position and item_value with start
//   high; the item is taken at a rising edge where start is high and busy is
//   low. busy stays high until the result has been shown.
//   Output: done is high for exactly one cycle with read_value, list_length
//   and status valid in that cycle. The receiver cannot stall the block.
// Timing
//   Every item goes through a check state that resolves the index and the
//   status. A read then fetches its element through the memory port; errors
//   and unknown operations go straight to the result.
//   Insert and remove move the later elements one per cycle through the
//   single memory port pair (one read, one write a cycle, registered read
//   data); insert then writes the new value at its index.
//   One item is in flight at a time; the next is taken the cycle after done.
// Reset
//   arst_n clears the length and the sequencer. The element memory is not
//   cleared: only entries below the length are ever read.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove
	import ilir_pkg::*;
#(
	parameter int LIST_CAPACITY = DEF_LIST_CAPACITY
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [OP_W-1:0]           operation,
	input  logic [MODE_W-1:0]         position_mode,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] item_value,
	output logic                      done,
	output logic signed [VALUE_W-1:0] read_value,
	output logic [LEN_W-1:0]          list_length,
	output logic [STAT_W-1:0]         status
);

	// count needs to hold the capacity itself; index addresses the store
	localparam int CW   = $clog2(LIST_CAPACITY + 1);
	localparam int IW   = $clog2(LIST_CAPACITY);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	state_t state_q, state_d;

	// latched item
	logic [OP_W-1:0]    op_q;
	logic [MODE_W-1:0]  mode_q;
	logic [POS_W-1:0]   pos_q;
	logic [VALUE_W-1:0] val_q;

	logic [CW-1:0]      count_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      src_q;
	logic [CW-1:0]      left_q;
	logic [VALUE_W-1:0] rd_q;
	logic [STAT_W-1:0]  st_q;

	// shift pipeline: read issued last cycle, write it now
	logic               pend_s1;
	logic [IW-1:0]      dst_s1;
	logic [VALUE_W-1:0] rdata_s1;

	// element memory
	logic [VALUE_W-1:0] mem [LIST_CAPACITY];
	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic               mem_re;
	logic [IW-1:0]      mem_raddr;

	// check-stage decode
	logic [CMPW-1:0]    cnt_ext;
	logic [CMPW-1:0]    pos_ext;
	logic [CMPW-1:0]    last_ext;
	logic [CMPW-1:0]    idx_ext;
	logic [CMPW-1:0]    left_ext;
	logic               is_ins;
	logic               is_rem;
	logic               is_known;
	logic               is_full;
	logic               is_empty;
	logic               pos_ok;
	logic [STAT_W-1:0]  chk_status;
	logic [IW-1:0]      chk_idx;
	logic               move_done;

	assign cnt_ext  = CMPW'(count_q);
	assign pos_ext  = CMPW'(pos_q);
	assign is_ins   = (op_q == OP_INSERT);
	assign is_rem   = (op_q == OP_REMOVE);
	assign is_known = is_ins || is_rem || (op_q == OP_READ);
	assign is_full  = (count_q == CW'(LIST_CAPACITY));
	assign is_empty = (count_q == '0);

	// the insert limit is the length (append); remove and read stop one short
	assign last_ext = is_ins ? cnt_ext : (cnt_ext - CMPW'(1));

	always_comb begin
		pos_ok  = 1'b0;
		idx_ext = '0;
		case (mode_q)
			MODE_INDEX: begin
				pos_ok  = (pos_ext <= last_ext);
				idx_ext = pos_ext;
			end
			MODE_FIRST: begin
				pos_ok  = 1'b1;
				idx_ext = '0;
			end
			MODE_LAST: begin
				pos_ok  = 1'b1;
				idx_ext = last_ext;
			end
			default: begin
				pos_ok  = 1'b0;
				idx_ext = '0;
			end
		endcase
	end

	assign chk_idx = idx_ext[IW-1:0];

	always_comb begin
		chk_status = STAT_OK;
		if (is_ins) begin
			if (is_full)
				chk_status = STAT_FULL;
			else if (!pos_ok)
				chk_status = STAT_RANGE;
		end else if (is_known) begin
			if (is_empty)
				chk_status = STAT_EMPTY;
			else if (!pos_ok)
				chk_status = STAT_RANGE;
		end
	end

	// elements to move: insert shifts [idx, count) up, remove shifts (idx, count) down
	assign left_ext  = is_ins ? (cnt_ext - idx_ext) : (cnt_ext - CMPW'(1) - idx_ext);
	assign move_done = (left_q == '0) && !pend_s1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!is_known || (chk_status != STAT_OK))
					state_d = S_RESP;
				else if (op_q == OP_READ)
					state_d = S_FETCH;
				else
					state_d = S_MOVE;
			end
			S_FETCH: begin
				state_d = S_RESP;
			end
			S_MOVE: begin
				if (move_done)
					state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = dst_s1;
		mem_wdata = rdata_s1;
		mem_re    = 1'b0;
		mem_raddr = src_q;
		case (state_q)
			S_CHECK: begin
				// fetch the element for a read that passed its checks
				if (is_known && (chk_status == STAT_OK) && (op_q == OP_READ)) begin
					mem_re    = 1'b1;
					mem_raddr = chk_idx;
				end
			end
			S_MOVE: begin
				if (pend_s1)
					mem_we = 1'b1;
				if (left_q != '0)
					mem_re = 1'b1;
				if (move_done && is_ins) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q;
					mem_wdata = val_q;
				end
			end
			default: begin
				mem_we = 1'b0;
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_s1 <= mem[mem_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == S_MOVE) && (left_q != '0);
			if ((state_q == S_MOVE) && move_done) begin
				if (is_ins)
					count_q <= count_q + CW'(1);
				else
					count_q <= count_q - CW'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			op_q   <= operation;
			mode_q <= position_mode;
			pos_q  <= position;
			val_q  <= item_value;
		end
		case (state_q)
			S_CHECK: begin
				idx_q  <= chk_idx;
				st_q   <= chk_status;
				rd_q   <= '0;
				left_q <= left_ext[CW-1:0];
				// start at the top for insert, just past the index for remove
				if (is_ins)
					src_q <= IW'(cnt_ext - CMPW'(1));
				else
					src_q <= IW'(idx_ext + CMPW'(1));
			end
			S_FETCH: begin
				rd_q <= rdata_s1;
			end
			S_MOVE: begin
				if (left_q != '0) begin
					left_q <= left_q - CW'(1);
					if (is_ins) begin
						src_q  <= src_q - IW'(1);
						dst_s1 <= src_q + IW'(1);
					end else begin
						src_q  <= src_q + IW'(1);
						dst_s1 <= src_q - IW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_RESP);
	assign read_value  = rd_q;
	assign status      = st_q;
	assign list_length = cnt_ext[LEN_W-1:0];

endmodule

### hw/rtl/ilir_checker.sv
// ----------------------------------------------------------------------------
// ilir_checker: port-level checks of the indexed list
// Watches the command and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module ilir_checker
	import ilir_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic signed [VALUE_W-1:0] read_value,
	input logic [LEN_W-1:0]          list_length,
	input logic [STAT_W-1:0]         status
);

	// an accepted item holds the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted but block not busy");

	// the block frees up right after its result
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block still busy after result");

	// failed requests return no data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STAT_OK) |-> read_value == '0)
		else $error("nonzero read value on error");

	// the length only moves when a result is shown
	a_len_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(list_length))
		else $error("length changed without a result");

	// empty status only with an empty list
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STAT_EMPTY) |-> list_length == '0)
		else $error("empty status with nonzero length");

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.read_value  (read_value),
	.list_length (list_length),
	.status      (status)
);

### tb/ilir_list_checker.sv
// ----------------------------------------------------------------------------
// ilir_list_checker: result predictor and comparator for the indexed list
// Watches the request and result channels and keeps a shadow copy of the
// list. Each accepted item is turned into an expected reply, and each done
// strobe is compared field by field with the oldest reply still waiting.
// ----------------------------------------------------------------------------
module ilir_list_checker
	import ilir_pkg::*;
#(
	parameter int LIST_CAPACITY = DEF_LIST_CAPACITY
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [OP_W-1:0]           operation,
	input  logic [MODE_W-1:0]         position_mode,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] item_value,
	input  logic                      done,
	input  logic signed [VALUE_W-1:0] read_value,
	input  logic [LEN_W-1:0]          list_length,
	input  logic [STAT_W-1:0]         status,
	output int unsigned               mismatches,
	output int unsigned               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [LEN_W-1:0]          list_length;
		logic [STAT_W-1:0]         status;
	} list_reply_t;

	logic signed [VALUE_W-1:0] shadow_store [LIST_CAPACITY];
	int unsigned               shadow_count;
	list_reply_t               reply_queue [$];

	initial begin
		mismatches = 0;
		pending = 0;
		shadow_count = 0;
	end

	task automatic report_mismatch(input string note);
		$display("[%0t] mismatch: %s", $time, note);
		mismatches++;
	endtask

	// Resolve the target slot; the limit is the count for insert and the
	// last element otherwise. Unknown modes never resolve.
	function automatic bit resolve_slot(input logic [MODE_W-1:0] mode,
			input logic [POS_W-1:0] pos, input bit for_insert,
			output int unsigned slot);
		int unsigned limit;
		limit = for_insert ? shadow_count : shadow_count - 1;
		slot = 0;
		case (mode)
			MODE_INDEX: begin
				if (pos > limit)
					return 1'b0;
				slot = pos;
				return 1'b1;
			end
			MODE_FIRST: return 1'b1;
			MODE_LAST: begin
				slot = limit;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Apply one request to the shadow list and form its reply.
	task automatic predict_reply(input logic [OP_W-1:0] op,
			input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
			input logic signed [VALUE_W-1:0] value, output list_reply_t reply);
		int unsigned slot;
		reply.read_value = '0;
		reply.status = STAT_OK;
		case (op)
			OP_INSERT: begin
				if (shadow_count >= LIST_CAPACITY)
					reply.status = STAT_FULL;
				else if (!resolve_slot(mode, pos, 1'b1, slot))
					reply.status = STAT_RANGE;
				else begin
					for (int i = shadow_count; i > slot; i--)
						shadow_store[i] = shadow_store[i-1];
					shadow_store[slot] = value;
					shadow_count++;
				end
			end
			OP_REMOVE, OP_READ: begin
				if (shadow_count == 0)
					reply.status = STAT_EMPTY;
				else if (!resolve_slot(mode, pos, 1'b0, slot))
					reply.status = STAT_RANGE;
				else if (op == OP_READ)
					reply.read_value = shadow_store[slot];
				else begin
					for (int i = slot; i + 1 < shadow_count; i++)
						shadow_store[i] = shadow_store[i+1];
					shadow_count--;
				end
			end
			default: ;
		endcase
		reply.list_length = shadow_count[LEN_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		list_reply_t want;
		if (!arst_n) begin
			shadow_count = 0;
			reply_queue.delete();
			pending <= 0;
		end else begin
			// compare the result first, then predict any newly accepted item
			if (done) begin
				if (reply_queue.size() == 0)
					report_mismatch($sformatf("result with nothing expected (len %0d st %0d)",
						list_length, status));
				else begin
					want = reply_queue.pop_front();
					if (read_value !== want.read_value)
						report_mismatch($sformatf("read_value %0d expected %0d",
							read_value, want.read_value));
					if (list_length !== want.list_length)
						report_mismatch($sformatf("list_length %0d expected %0d",
							list_length, want.list_length));
					if (status !== want.status)
						report_mismatch($sformatf("status %0d expected %0d",
							status, want.status));
				end
			end
			if (start && !busy) begin
				predict_reply(operation, position_mode, position, item_value, want);
				reply_queue.push_back(want);
			end
			pending <= reply_queue.size();
		end
	end

endmodule

### tb/tb_indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove: stimulus and verdict for the indexed list
// Drives a directed opening and then phases of random requests that fill,
// churn and drain the list, with random sender gaps. The checker beside the
// block predicts every reply; this module waits for the run to settle and
// reports the outcome.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_remove;
	timeunit 1ns;
	timeprecision 1ps;

	import ilir_pkg::*;

	localparam int                  CAPACITY       = DEF_LIST_CAPACITY;
	localparam int                  RESET_CYCLES   = 4;
	localparam int                  PHASE_ITEMS    = 140;
	localparam int                  PHASE_COUNT    = 10;
	// longest legal quiet stretch is a long sender gap plus a full shift
	localparam int unsigned         WATCHDOG_LIMIT = 4000;
	localparam logic [OP_W-1:0]     OP_UNKNOWN     = 2'd3;
	localparam logic [MODE_W-1:0]   MODE_UNKNOWN   = 2'd3;
	localparam logic [VALUE_W-1:0]  WORD_MAX       = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0]  WORD_MIN       = 32'h8000_0000;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      start         = 1'b0;
	logic                      busy;
	logic [OP_W-1:0]           operation     = OP_READ;
	logic [MODE_W-1:0]         position_mode = MODE_INDEX;
	logic [POS_W-1:0]          position      = '0;
	logic signed [VALUE_W-1:0] item_value    = '0;
	logic                      done;
	logic signed [VALUE_W-1:0] read_value;
	logic [LEN_W-1:0]          list_length;
	logic [STAT_W-1:0]         status;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned quiet_cycles = 0;

	always #5 clk = ~clk;

	indexed_list_insert_remove #(
		.LIST_CAPACITY(CAPACITY)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.position_mode(position_mode),
		.position     (position),
		.item_value   (item_value),
		.done         (done),
		.read_value   (read_value),
		.list_length  (list_length),
		.status       (status)
	);

	ilir_list_checker #(
		.LIST_CAPACITY(CAPACITY)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.position_mode(position_mode),
		.position     (position),
		.item_value   (item_value),
		.done         (done),
		.read_value   (read_value),
		.list_length  (list_length),
		.status       (status),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	// Watchdog: end the run once nothing has moved on either channel for too
	// long. Any accepted item or any result restarts the count.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Present one item and hold it until the block takes it. Call at a rising
	// edge; returns at the edge that accepted the item. busy read right after
	// the edge is still the value the block saw at that edge.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [MODE_W-1:0] mode,
			input logic [POS_W-1:0] pos, input logic signed [VALUE_W-1:0] value);
		operation     <= op;
		position_mode <= mode;
		position      <= pos;
		item_value    <= value;
		start         <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start for a number of cycles; zero keeps start high so the next
	// item follows back to back.
	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Hold the sender until every expected result has come back. The first
	// edge lets the checker count the item accepted last.
	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		if (roll < 98)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Random request weighted by the phase: insert and remove shares in
	// percent, reads fill the rest and a sliver of unknown operations.
	task automatic send_random_item(input int unsigned insert_pct,
			input int unsigned remove_pct);
		int unsigned       roll;
		logic [OP_W-1:0]   op;
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0]  pos;
		logic [VALUE_W-1:0] value;
		roll = $urandom_range(99);
		if (roll < insert_pct)
			op = OP_INSERT;
		else if (roll < insert_pct + remove_pct)
			op = OP_REMOVE;
		else if (roll < 97)
			op = OP_READ;
		else
			op = OP_UNKNOWN;
		roll = $urandom_range(99);
		if (roll < 38)
			mode = MODE_INDEX;
		else if (roll < 68)
			mode = MODE_FIRST;
		else if (roll < 96)
			mode = MODE_LAST;
		else
			mode = MODE_UNKNOWN;
		// keep most indexes near the live range, but toggle every bit
		if ($urandom_range(99) < 88)
			pos = POS_W'($urandom_range(CAPACITY + 2, 0));
		else
			pos = POS_W'($urandom_range(127, 0));
		roll = $urandom_range(99);
		case (roll % 4)
			0: value = WORD_MAX;
			1: value = WORD_MIN;
			2: value = '0;
			default: value = '1;
		endcase
		if (roll >= 10)
			value = $urandom();
		send_item(op, mode, pos, value);
	endtask

	initial begin
		int unsigned insert_pct;
		int unsigned remove_pct;
		bit          steady;

		// hold reset, then release it once on a clean edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: empty list errors, range errors on insert, the
		// value extremes, every mode, an unknown mode and an unknown operation.
		send_item(OP_READ,   MODE_INDEX,   7'd0,   '0);
		send_item(OP_REMOVE, MODE_LAST,    7'd0,   '0);
		send_item(OP_READ,   MODE_UNKNOWN, 7'd0,   '0);
		send_item(OP_INSERT, MODE_INDEX,   7'd1,   32'sd5);
		send_item(OP_INSERT, MODE_FIRST,   7'd0,   WORD_MAX);
		send_item(OP_INSERT, MODE_LAST,    7'd0,   WORD_MIN);
		send_item(OP_INSERT, MODE_INDEX,   7'd1,   -32'sd1);
		send_item(OP_INSERT, MODE_INDEX,   7'd3,   32'sd0);
		send_item(OP_INSERT, MODE_UNKNOWN, 7'd0,   32'sd9);
		send_item(OP_INSERT, MODE_INDEX,   7'd127, 32'sd9);
		send_item(OP_READ,   MODE_FIRST,   7'd0,   '0);
		send_item(OP_READ,   MODE_LAST,    7'd0,   '0);
		send_item(OP_READ,   MODE_INDEX,   7'd1,   '0);
		send_item(OP_READ,   MODE_INDEX,   7'd4,   '0);
		send_item(OP_READ,   MODE_INDEX,   7'd127, '0);
		send_item(OP_UNKNOWN, MODE_INDEX,  7'd0,   32'sd3);
		send_item(OP_REMOVE, MODE_UNKNOWN, 7'd0,   '0);
		send_item(OP_REMOVE, MODE_INDEX,   7'd4,   '0);
		send_item(OP_REMOVE, MODE_INDEX,   7'd1,   '0);
		send_item(OP_REMOVE, MODE_LAST,    7'd0,   '0);
		send_item(OP_REMOVE, MODE_FIRST,   7'd0,   '0);
		send_item(OP_REMOVE, MODE_FIRST,   7'd0,   '0);
		send_item(OP_READ,   MODE_LAST,    7'd0,   '0);
		wait_for_drain();
		@(posedge clk);

		// Random phases: fill past full, churn, drain to empty, churn again.
		// Some phases run back to back; each ends with the sender holding off
		// until every reply is in.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase % 4)
				0: begin
					insert_pct = 85;
					remove_pct = 5;
				end
				2: begin
					insert_pct = 10;
					remove_pct = 75;
				end
				default: begin
					insert_pct = 45;
					remove_pct = 35;
				end
			endcase
			steady = ($urandom_range(3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_random_item(insert_pct, remove_pct);
				if (!steady)
					pause_sender(pick_gap());
			end
			wait_for_drain();
			@(posedge clk);
		end

		// let a stray late result show up before the verdict
		repeat (CAPACITY + 8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
